// File: design/pcs_pkg.sv
// Shared package for the progress counter scanner.
// Holds character codes, state and result encodings and byte class helpers.
// Depends on nothing; every design file imports it.
package pcs_pkg;

  localparam int unsigned CountWidthDef = 30;
  localparam logic [63:0] LimitReset    = 64'd1000000000;
  localparam logic [6:0]  PercentMax    = 7'd100;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] ChUpperZ  = 8'h5A;
  localparam logic [7:0] ChLowerA  = 8'h61;
  localparam logic [7:0] ChLowerZ  = 8'h7A;
  localparam logic [7:0] ChLineStart = 8'h00;

  typedef enum logic [4:0] {
    PhIdle   = 5'b00001,
    PhSkip   = 5'b00010,
    PhFirst  = 5'b00100,
    PhSlash  = 5'b01000,
    PhSecond = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    MatchNone     = 2'd0,
    MatchPercent  = 2'd1,
    MatchFraction = 2'd2
  } match_e;

  typedef enum logic {
    KindChar = 1'b0,
    KindEol  = 1'b1
  } item_kind_e;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || ((c >= ChUpperA) && (c <= ChUpperZ)) ||
           ((c >= ChLowerA) && (c <= ChLowerZ));
  endfunction

endpackage

// File: design/pcs_scan_core.sv
// Line scanner state and per-byte update for the progress counter scanner.
// Updates the token state for one item per cycle while take_i is high and forms the line result.
// Depends on pcs_pkg.
module pcs_scan_core import pcs_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   take_i,
  input  item_kind_e             kind_i,
  input  logic [7:0]             byte_i,
  input  logic [COUNT_WIDTH-1:0] limit_i,
  output match_e                 res_kind_o,
  output logic [6:0]             res_percent_o,
  output logic [COUNT_WIDTH-1:0] res_done_o,
  output logic [COUNT_WIDTH-1:0] res_total_o
);

  localparam int unsigned AccWidth = COUNT_WIDTH + 4;

  phase_e                 phase_q, phase_d;
  logic [7:0]             prev_q, prev_d;
  logic [COUNT_WIDTH-1:0] first_q, first_d;
  logic                   first_ok_q, first_ok_d;
  logic [COUNT_WIDTH-1:0] second_q, second_d;
  logic                   second_ok_q, second_ok_d;
  match_e                 best_kind_q, best_kind_d;
  logic [6:0]             best_pct_q, best_pct_d;
  logic [COUNT_WIDTH-1:0] best_done_q, best_done_d;
  logic [COUNT_WIDTH-1:0] best_total_q, best_total_d;

  logic                   is_eol;
  logic                   dig;
  logic [3:0]             dval;
  logic [COUNT_WIDTH-1:0] acc_in;
  logic                   acc_ok_in;
  logic [AccWidth-1:0]    acc_wide;
  logic [AccWidth-1:0]    acc_next;
  logic                   acc_ok_out;
  logic [COUNT_WIDTH-1:0] acc_val_out;
  logic                   tail_ok;
  logic                   frac_ok;
  logic                   pct_ok;

  assign is_eol = (kind_i == KindEol);
  assign dig    = is_digit(byte_i);
  assign dval   = byte_i[3:0];

  // One shared multiply-by-ten accumulator for whichever number is growing.
  always_comb begin
    acc_in    = '0;
    acc_ok_in = 1'b1;
    if (phase_q == PhFirst) begin
      acc_in    = first_q;
      acc_ok_in = first_ok_q;
    end else if (phase_q == PhSecond) begin
      acc_in    = second_q;
      acc_ok_in = second_ok_q;
    end
  end

  assign acc_wide    = {4'b0, acc_in};
  assign acc_next    = (acc_wide << 3) + (acc_wide << 1) +
                       {{(AccWidth-4){1'b0}}, dval};
  assign acc_ok_out  = acc_ok_in && (acc_next <= {4'b0, limit_i});
  assign acc_val_out = acc_ok_out ? acc_next[COUNT_WIDTH-1:0] : acc_in;

  assign tail_ok = is_eol ||
                   (!is_alnum(byte_i) && (byte_i != ChSlash) && (byte_i != ChDot));
  assign frac_ok = (phase_q == PhSecond) && first_ok_q && second_ok_q &&
                   (second_q != '0) && (first_q <= second_q) && tail_ok;
  assign pct_ok  = first_ok_q && (byte_i == ChPercent) &&
                   (first_q <= {{(COUNT_WIDTH-7){1'b0}}, PercentMax});

  always_comb begin
    phase_d      = phase_q;
    prev_d       = byte_i;
    first_d      = first_q;
    first_ok_d   = first_ok_q;
    second_d     = second_q;
    second_ok_d  = second_ok_q;
    best_kind_d  = best_kind_q;
    best_pct_d   = best_pct_q;
    best_done_d  = best_done_q;
    best_total_d = best_total_q;

    if (frac_ok && (is_eol || !dig)) begin
      best_kind_d  = MatchFraction;
      best_pct_d   = '0;
      best_done_d  = first_q;
      best_total_d = second_q;
    end

    if (!is_eol) begin
      case (phase_q)
        PhSkip: begin
          if (!dig) begin
            phase_d = PhIdle;
          end
        end
        PhFirst: begin
          if (dig) begin
            first_d    = acc_val_out;
            first_ok_d = acc_ok_out;
          end else if (pct_ok) begin
            best_kind_d  = MatchPercent;
            best_pct_d   = first_q[6:0];
            best_done_d  = '0;
            best_total_d = '0;
            phase_d      = PhIdle;
          end else if (byte_i == ChSlash) begin
            phase_d = PhSlash;
          end else begin
            phase_d = PhIdle;
          end
        end
        PhSlash: begin
          if (dig) begin
            second_d    = acc_val_out;
            second_ok_d = acc_ok_out;
            phase_d     = PhSecond;
          end else begin
            phase_d = PhIdle;
          end
        end
        PhSecond: begin
          if (dig) begin
            second_d    = acc_val_out;
            second_ok_d = acc_ok_out;
          end else begin
            phase_d = PhIdle;
          end
        end
        default: begin
          if (dig) begin
            if (is_alnum(prev_q) || (prev_q == ChDot)) begin
              phase_d = PhSkip;
            end else begin
              first_d    = acc_val_out;
              first_ok_d = acc_ok_out;
              phase_d    = PhFirst;
            end
          end else begin
            phase_d = PhIdle;
          end
        end
      endcase
    end
  end

  assign res_kind_o    = best_kind_d;
  assign res_percent_o = best_pct_d;
  assign res_done_o    = best_done_d;
  assign res_total_o   = best_total_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      prev_q       <= ChLineStart;
      first_q      <= '0;
      first_ok_q   <= 1'b1;
      second_q     <= '0;
      second_ok_q  <= 1'b1;
      best_kind_q  <= MatchNone;
      best_pct_q   <= '0;
      best_done_q  <= '0;
      best_total_q <= '0;
    end else if (take_i) begin
      if (is_eol) begin
        phase_q      <= PhIdle;
        prev_q       <= ChLineStart;
        first_q      <= '0;
        first_ok_q   <= 1'b1;
        second_q     <= '0;
        second_ok_q  <= 1'b1;
        best_kind_q  <= MatchNone;
        best_pct_q   <= '0;
        best_done_q  <= '0;
        best_total_q <= '0;
      end else begin
        phase_q      <= phase_d;
        prev_q       <= prev_d;
        first_q      <= first_d;
        first_ok_q   <= first_ok_d;
        second_q     <= second_d;
        second_ok_q  <= second_ok_d;
        best_kind_q  <= best_kind_d;
        best_pct_q   <= best_pct_d;
        best_done_q  <= best_done_d;
        best_total_q <= best_total_d;
      end
    end
  end

endmodule

// File: design/pcs_result_reg.sv
// Output register for the progress counter scanner's line results.
// Holds one result until the downstream side takes it.
// Depends on pcs_pkg.
module pcs_result_reg import pcs_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  match_e                 kind_i,
  input  logic [6:0]             percent_i,
  input  logic [COUNT_WIDTH-1:0] done_i,
  input  logic [COUNT_WIDTH-1:0] total_i,
  output logic                   free_o,
  output logic                   valid_o,
  input  logic                   ready_i,
  output match_e                 kind_o,
  output logic [6:0]             percent_o,
  output logic [COUNT_WIDTH-1:0] done_o,
  output logic [COUNT_WIDTH-1:0] total_o
);

  logic                   vld_q;
  match_e                 kind_q;
  logic [6:0]             pct_q;
  logic [COUNT_WIDTH-1:0] done_q;
  logic [COUNT_WIDTH-1:0] total_q;

  assign free_o = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= 1'b1;
    end else if (ready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      kind_q  <= kind_i;
      pct_q   <= percent_i;
      done_q  <= done_i;
      total_q <= total_i;
    end
  end

  assign valid_o   = vld_q;
  assign kind_o    = kind_q;
  assign percent_o = pct_q;
  assign done_o    = done_q;
  assign total_o   = total_q;

endmodule

// File: design/progress_counter_scanner.sv
// Top level of the progress counter scanner.
// Instantiates pcs_scan_core and pcs_result_reg; depends on pcs_pkg.
//
// The slave stream carries a text line one byte per transfer: tdata holds the
// byte and tuser says whether the transfer is a byte or the end of the line.
// Bytes give no output. Each end-of-line transfer gives exactly one result on
// the master stream: tuser holds the match kind, and tdata holds the
// percentage, the done count and the total count. The last progress token of
// the line wins, and the scanner clears itself for the next line.
// One item is taken per cycle unless an end of line waits for the result slot. An accepted
// transfer is registered in the input register, and its result is then registered in the
// output register. The per-byte path is one multiply-by-ten add and a few compares.
// When the receiver stalls, the pending result is held in the output register
// and bytes keep flowing; only a further end of line waits, in the input
// register, until the result slot frees up.
// Reset empties both registers, clears the line state and sets the counter
// limit to its default. The limit may be written only while the block is idle.
module progress_counter_scanner import pcs_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [COUNT_WIDTH-1:0] cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [7:0] byte_req
  input  logic                   s_axis_tuser,   // [0] kind
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [6:0] percent, then done_count, then total_count, then zero padding
  output logic [((7+2*COUNT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  output logic [1:0]             m_axis_tuser    // [1:0] match_kind
);

  localparam int unsigned OutDataWidth = ((7 + 2*COUNT_WIDTH + 7) / 8) * 8;
  localparam int unsigned PadWidth     = OutDataWidth - 7 - 2*COUNT_WIDTH;

  logic [COUNT_WIDTH-1:0] limit_val_q;
  logic                   in_vld_q;
  item_kind_e             in_kind_q;
  logic [7:0]             in_byte_q;
  logic                   core_take;
  logic                   out_free;
  logic                   out_load;
  match_e                 res_kind;
  logic [6:0]             res_pct;
  logic [COUNT_WIDTH-1:0] res_done;
  logic [COUNT_WIDTH-1:0] res_total;
  match_e                 out_kind;
  logic [6:0]             out_pct;
  logic [COUNT_WIDTH-1:0] out_done;
  logic [COUNT_WIDTH-1:0] out_total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_val_q <= LimitReset[COUNT_WIDTH-1:0];
    end else if (cfg_we_i) begin
      limit_val_q <= cfg_wdata_i;
    end
  end

  assign core_take     = in_vld_q && ((in_kind_q == KindChar) || out_free);
  assign out_load      = core_take && (in_kind_q == KindEol);
  assign s_axis_tready = !in_vld_q || core_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind_q <= item_kind_e'(s_axis_tuser);
      in_byte_q <= s_axis_tdata;
    end
  end

  pcs_scan_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (core_take),
    .kind_i        (in_kind_q),
    .byte_i        (in_byte_q),
    .limit_i       (limit_val_q),
    .res_kind_o    (res_kind),
    .res_percent_o (res_pct),
    .res_done_o    (res_done),
    .res_total_o   (res_total)
  );

  pcs_result_reg #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_result (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (out_load),
    .kind_i    (res_kind),
    .percent_i (res_pct),
    .done_i    (res_done),
    .total_i   (res_total),
    .free_o    (out_free),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .kind_o    (out_kind),
    .percent_o (out_pct),
    .done_o    (out_done),
    .total_o   (out_total)
  );

  assign m_axis_tdata = {{PadWidth{1'b0}}, out_total, out_done, out_pct};
  assign m_axis_tuser = out_kind;

endmodule

// File: bench/pcs_line_checker.sv
`timescale 1ns / 1ps
// Checker for the progress counter scanner: watches both streams and the limit port,
// predicts the report of each line and compares it with the block's output.
// Depends on pcs_pkg.
module pcs_line_checker import pcs_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = CountWidthDef,
  parameter int unsigned TDATA_WIDTH = ((7 + 2 * COUNT_WIDTH + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [COUNT_WIDTH-1:0] cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,
  input  logic                   s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [TDATA_WIDTH-1:0] m_axis_tdata,
  input  logic [1:0]             m_axis_tuser,
  output int                     errors_o,
  output int                     pending_o
);

  typedef struct packed {
    match_e                 kind;
    logic [6:0]             percent;
    logic [COUNT_WIDTH-1:0] done;
    logic [COUNT_WIDTH-1:0] total;
  } line_report_t;

  // Counters carry their valid flag in the top bit.
  logic [COUNT_WIDTH-1:0] limit_r;
  phase_e                 phase_r;
  logic [7:0]             prev_r;
  logic [COUNT_WIDTH:0]   done_acc;
  logic [COUNT_WIDTH:0]   total_acc;
  line_report_t           best_r;
  line_report_t           line_reports_q[$];
  int                     mismatches = 0;

  assign errors_o = mismatches;

  function automatic logic dec_char(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic word_char(input logic [7:0] c);
    return dec_char(c) || ((c >= ChUpperA) && (c <= ChUpperZ)) ||
           ((c >= ChLowerA) && (c <= ChLowerZ));
  endfunction

  function automatic logic [COUNT_WIDTH:0] add_digit(input logic [COUNT_WIDTH:0] acc,
                                                     input logic [7:0] c);
    longint unsigned n;
    if (!acc[COUNT_WIDTH]) return acc;
    n = longint'(acc[COUNT_WIDTH-1:0]) * 10 + longint'(c) - longint'(ChZero);
    if (n > longint'(limit_r)) return {1'b0, acc[COUNT_WIDTH-1:0]};
    return {1'b1, n[COUNT_WIDTH-1:0]};
  endfunction

  task automatic clear_line();
    phase_r   = PhIdle;
    prev_r    = ChLineStart;
    done_acc  = {1'b1, {COUNT_WIDTH{1'b0}}};
    total_acc = {1'b1, {COUNT_WIDTH{1'b0}}};
    best_r    = '{MatchNone, 7'd0, '0, '0};
  endtask

  task automatic close_fraction(input logic [7:0] c, input logic at_end);
    logic tail_ok;
    tail_ok = at_end || (!word_char(c) && c != ChSlash && c != ChDot);
    if (done_acc[COUNT_WIDTH] && total_acc[COUNT_WIDTH] &&
        total_acc[COUNT_WIDTH-1:0] != '0 &&
        done_acc[COUNT_WIDTH-1:0] <= total_acc[COUNT_WIDTH-1:0] && tail_ok) begin
      best_r = '{MatchFraction, 7'd0, done_acc[COUNT_WIDTH-1:0], total_acc[COUNT_WIDTH-1:0]};
    end
  endtask

  task automatic scan_byte(input logic [7:0] c);
    case (phase_r)
      PhSkip: begin
        if (!dec_char(c)) phase_r = PhIdle;
      end
      PhFirst: begin
        if (dec_char(c)) begin
          done_acc = add_digit(done_acc, c);
        end else if (done_acc[COUNT_WIDTH] && c == ChPercent &&
                     done_acc[COUNT_WIDTH-1:0] <= PercentMax) begin
          best_r  = '{MatchPercent, done_acc[6:0], '0, '0};
          phase_r = PhIdle;
        end else if (c == ChSlash) begin
          phase_r = PhSlash;
        end else begin
          phase_r = PhIdle;
        end
      end
      PhSlash: begin
        if (dec_char(c)) begin
          total_acc = add_digit({1'b1, {COUNT_WIDTH{1'b0}}}, c);
          phase_r   = PhSecond;
        end else begin
          phase_r = PhIdle;
        end
      end
      PhSecond: begin
        if (dec_char(c)) begin
          total_acc = add_digit(total_acc, c);
        end else begin
          close_fraction(c, 1'b0);
          phase_r = PhIdle;
        end
      end
      default: begin
        if (!dec_char(c)) begin
          phase_r = PhIdle;
        end else if (word_char(prev_r) || prev_r == ChDot) begin
          phase_r = PhSkip;
        end else begin
          done_acc = add_digit({1'b1, {COUNT_WIDTH{1'b0}}}, c);
          phase_r  = PhFirst;
        end
      end
    endcase
    prev_r = c;
  endtask

  task automatic finish_line();
    if (phase_r == PhSecond) close_fraction(ChLineStart, 1'b1);
    line_reports_q.push_back(best_r);
    clear_line();
  endtask

  task automatic check_report();
    line_report_t want;
    line_report_t got;
    got.kind    = match_e'(m_axis_tuser);
    got.percent = m_axis_tdata[6:0];
    got.done    = m_axis_tdata[7 +: COUNT_WIDTH];
    got.total   = m_axis_tdata[7 + COUNT_WIDTH +: COUNT_WIDTH];
    if (line_reports_q.size() == 0) begin
      $error("result transfer with no end of line pending: kind %0d", got.kind);
      mismatches++;
      return;
    end
    want = line_reports_q.pop_front();
    if (got.kind !== want.kind) begin
      $error("match_kind: expected %0d, actual %0d", want.kind, got.kind);
      mismatches++;
    end
    if (got.percent !== want.percent) begin
      $error("percent: expected %0d, actual %0d", want.percent, got.percent);
      mismatches++;
    end
    if (got.done !== want.done) begin
      $error("done_count: expected %0d, actual %0d", want.done, got.done);
      mismatches++;
    end
    if (got.total !== want.total) begin
      $error("total_count: expected %0d, actual %0d", want.total, got.total);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_r = LimitReset[COUNT_WIDTH-1:0];
      clear_line();
      line_reports_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) limit_r = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        if (item_kind_e'(s_axis_tuser) == KindEol) finish_line();
        else scan_byte(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) check_report();
      pending_o <= line_reports_q.size();
    end
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Top of the progress counter scanner bench: clock, reset, line stimulus and verdict.
// Depends on pcs_pkg, progress_counter_scanner and pcs_line_checker.
module tb_top;
  import pcs_pkg::*;

  localparam int unsigned CountWidth  = CountWidthDef;
  localparam int unsigned TdataWidth  = ((7 + 2 * CountWidth + 7) / 8) * 8;
  localparam int unsigned PhaseItems  = 105;
  localparam int unsigned LimitPhases = 7;
  localparam longint unsigned LimitSteps[LimitPhases] =
    '{1, 0, 100, 999, (64'd1 << CountWidth) - 1, 65535, LimitReset};

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CountWidth-1:0] cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = 8'h00;
  logic                  s_axis_tuser  = KindChar;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TdataWidth-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;

  int              errors;
  int              pending;
  bit              stalls_on = 1'b0;
  int unsigned     hold_left = 0;
  int unsigned     sent      = 0;
  longint unsigned limit_now = LimitReset;
  logic [7:0]      line_q[$];

  progress_counter_scanner #(.COUNT_WIDTH(CountWidth)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  pcs_line_checker #(.COUNT_WIDTH(CountWidth), .TDATA_WIDTH(TdataWidth)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      hold_left     <= $urandom_range(0, 11);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [7:0] any_letter();
    if ($urandom_range(0, 1) != 0) return 8'($urandom_range(ChUpperA, ChUpperZ));
    return 8'($urandom_range(ChLowerA, ChLowerZ));
  endfunction

  function automatic logic [7:0] gap_char();
    string marks;
    marks = " ,:;()[]=-";
    return marks[$urandom_range(0, marks.len() - 1)];
  endfunction

  function automatic longint unsigned pick_count();
    case ($urandom_range(0, 8))
      0:       return $urandom_range(0, 9);
      1:       return $urandom_range(0, 120);
      2:       return 99 + $urandom_range(0, 3);
      3:       return limit_now;
      4:       return limit_now + 1;
      5:       return $urandom_range(0, 32'(limit_now));
      6:       return {$urandom, $urandom} % 64'd100_000_000_000;
      7:       return $urandom_range(0, 999);
      default: return $urandom_range(0, 99999);
    endcase
  endfunction

  task automatic push_text(input string s);
    foreach (s[i]) line_q.push_back(s[i]);
  endtask

  task automatic push_count(input longint unsigned v);
    logic [7:0] digits[$];
    int         zeros;
    zeros = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
    repeat (zeros) line_q.push_back(ChZero);
    do begin
      digits.push_front(ChZero + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digits[i]) line_q.push_back(digits[i]);
  endtask

  task automatic build_line();
    int              tokens;
    longint unsigned done_val;
    longint unsigned total_val;
    tokens = $urandom_range(1, 4);
    repeat (tokens) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          push_count(pick_count());
          if ($urandom_range(0, 6) == 0) begin
            line_q.push_back(ChDot);
            push_count($urandom_range(0, 9));
          end
          line_q.push_back(ChPercent);
        end
        3, 4, 5: begin
          total_val = pick_count();
          case ($urandom_range(0, 5))
            0, 1, 2: done_val = (total_val < 64'h1_0000_0000) ?
                                $urandom_range(0, 32'(total_val)) : total_val / 3;
            3:       done_val = total_val;
            4:       done_val = total_val + 1;
            default: done_val = pick_count();
          endcase
          push_count(done_val);
          line_q.push_back(ChSlash);
          push_count(total_val);
          case ($urandom_range(0, 7))
            0:       line_q.push_back(gap_char());
            1:       line_q.push_back(any_letter());
            2:       line_q.push_back(ChSlash);
            3:       line_q.push_back(ChDot);
            4:       ;
            5:       line_q.push_back(8'($urandom_range(0, 255)));
            6:       line_q.push_back(ChPercent);
            default: line_q.push_back(gap_char());
          endcase
        end
        6: begin
          line_q.push_back(($urandom_range(0, 1) != 0) ? any_letter() : ChDot);
          push_count(pick_count());
          line_q.push_back(ChPercent);
        end
        7: begin
          repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(0, 255)));
        end
        8: begin
          case ($urandom_range(0, 3))
            0: begin
              push_count(pick_count());
              line_q.push_back(ChSlash);
              line_q.push_back(any_letter());
            end
            1: begin
              line_q.push_back(ChSlash);
              push_count(pick_count());
            end
            2: line_q.push_back(ChPercent);
            default: begin
              push_count(pick_count());
              line_q.push_back(ChSlash);
              line_q.push_back(ChSlash);
              push_count(pick_count());
            end
          endcase
        end
        default: line_q.push_back(gap_char());
      endcase
      if ($urandom_range(0, 3) != 0) line_q.push_back(gap_char());
    end
  endtask

  task automatic send_item(input item_kind_e kind, input logic [7:0] data);
    if (stalls_on && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_item(KindChar, line_q[i]);
    send_item(KindEol, 8'($urandom_range(0, 255)));
    line_q.delete();
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_limit(input longint unsigned value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CountWidth'(value);
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    limit_now = value;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    stalls_on <= 1'b1;

    push_text("100%");
    send_line();
    push_text("007/9");
    send_line();
    push_text("v2 3/4.");
    send_line();
    line_q.push_back(8'h00);
    push_text("5%");
    line_q.push_back(8'hFF);
    send_line();
    send_line();

    for (int p = 0; p <= LimitPhases; p++) begin
      if (p > 0) set_limit(LimitSteps[p-1]);
      stalls_on <= (p < LimitPhases) && ($urandom_range(0, 4) != 0);
      sent = 0;
      while (sent < PhaseItems) begin
        build_line();
        send_line();
      end
    end

    drain();
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule

// File: progress_counter_scanner.f
design/pcs_pkg.sv
design/pcs_scan_core.sv
design/pcs_result_reg.sv
design/progress_counter_scanner.sv
bench/pcs_line_checker.sv
bench/tb_top.sv
